### src/pending_token_table_with_timeout_top_macros.svh
// assertion macros shared by the pending token table modules
`ifndef PENDING_TOKEN_TABLE_WITH_TIMEOUT_TOP_MACROS_SVH
`define PENDING_TOKEN_TABLE_WITH_TIMEOUT_TOP_MACROS_SVH

// same-cycle implication on i_clk, disabled while i_rst_n is low
`define PTT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on i_clk, disabled while i_rst_n is low
`define PTT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/ptt_pkg.sv
// shared types and codes for the pending token table
package ptt_pkg;

    localparam logic REQ_ADD    = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    localparam logic [1:0] STAT_DONE      = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

    localparam int TIME_W  = 32;
    localparam int TOKEN_W = 64;
    localparam int STAT_W  = 2;

    localparam logic [TIME_W-1:0] LIMIT_RESET = 32'd5000;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic issue;
        logic clear;
        logic post;
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_end;
        logic ev_busy;
        logic out_free;
    } t_dp_stat;

endpackage

### src/ptt_ctrl.sv
// controller state machine for the pending token table
`include "pending_token_table_with_timeout_top_macros.svh"

module ptt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ptt_pkg::t_dp_stat i_stat,
    output ptt_pkg::t_dp_cmd  o_cmd
);
    import ptt_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   scan_drained;

    assign scan_drained = i_stat.cnt_end && !i_stat.ev_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                if (i_stat.cnt_end) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.clear = 1'b1;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.issue = !i_stat.cnt_end;
                if (scan_drained) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.post = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    `PTT_ASSERT_NEXT(a_load_starts_scan, o_cmd.load, r_state == ST_SCAN, "load without scan")
    `PTT_ASSERT_NOW(a_done_drained, r_state == ST_DONE, scan_drained, "scan not drained")
    `PTT_ASSERT_NOW(a_post_has_room, o_cmd.post, i_stat.out_free, "post over waiting result")

endmodule

### src/ptt_datapath.sv
// slot memories, scan pipeline and result register of the pending token table
`include "pending_token_table_with_timeout_top_macros.svh"

module ptt_datapath #(
    parameter int TABLE_SLOTS = 128,
    parameter int TOKEN_BYTES = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ptt_pkg::t_dp_cmd              i_cmd,
    output ptt_pkg::t_dp_stat             o_stat,
    input  logic                          i_cfg_wr_en,
    input  logic [ptt_pkg::TIME_W-1:0]    i_cfg_wr_data,
    input  logic                          i_req,
    input  logic [ptt_pkg::TOKEN_W-1:0]   i_token,
    input  logic [ptt_pkg::TIME_W-1:0]    i_now,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ptt_pkg::STAT_W-1:0]    o_status,
    output logic [ptt_pkg::TIME_W-1:0]    o_elapsed
);
    import ptt_pkg::*;

    localparam int TOK_W = 8 * TOKEN_BYTES;
    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

    // slot stores
    logic [TOK_W-1:0]  r_mem_token [TABLE_SLOTS];
    logic [TIME_W-1:0] r_mem_stamp [TABLE_SLOTS];
    logic              r_mem_valid [TABLE_SLOTS];

    logic [TIME_W-1:0] r_limit;
    logic              r_req;
    logic [TOK_W-1:0]  r_tok;
    logic [TIME_W-1:0] r_now;

    logic [CNT_W-1:0]  r_cnt;
    logic              r_ev_vld;
    logic [IDX_W-1:0]  r_ev_idx;
    logic [TOK_W-1:0]  r_rd_token;
    logic [TIME_W-1:0] r_rd_stamp;
    logic              r_rd_valid;

    logic              r_found;
    logic [TIME_W-1:0] r_elapsed;

    logic              r_out_vld;
    logic [STAT_W-1:0] r_out_status;
    logic [TIME_W-1:0] r_out_elapsed;

    logic [TIME_W-1:0] age;
    logic              live;
    logic              add_hit;
    logic              rem_hit;
    logic              v_we;
    logic [IDX_W-1:0]  v_addr;
    logic              v_din;
    logic [IDX_W-1:0]  rd_addr;
    logic [STAT_W-1:0] n_status;
    logic              cnt_step;

    assign rd_addr  = r_cnt[IDX_W-1:0];
    assign cnt_step = i_cmd.issue || i_cmd.clear;

    // evaluation of the entry read in the previous cycle
    assign age     = r_now - r_rd_stamp;
    assign live    = r_rd_valid && !(age > r_limit);
    assign add_hit = r_ev_vld && !r_found && (r_req == REQ_ADD) && !live;
    assign rem_hit = r_ev_vld && !r_found && (r_req == REQ_REMOVE) && live
                     && (r_rd_token == r_tok);

    always_comb begin
        v_we   = 1'b0;
        v_addr = r_ev_idx;
        v_din  = live;
        if (i_cmd.clear) begin
            v_we   = 1'b1;
            v_addr = rd_addr;
            v_din  = 1'b0;
        end else if (r_ev_vld) begin
            v_we = 1'b1;
            if (add_hit) begin
                v_din = 1'b1;
            end else if (rem_hit) begin
                v_din = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_we) begin
            r_mem_valid[v_addr] <= v_din;
        end
        if (add_hit) begin
            r_mem_token[r_ev_idx] <= r_tok;
            r_mem_stamp[r_ev_idx] <= r_now;
        end
        r_rd_token <= r_mem_token[rd_addr];
        r_rd_stamp <= r_mem_stamp[rd_addr];
        r_rd_valid <= r_mem_valid[rd_addr];
        r_ev_idx   <= rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= LIMIT_RESET;
            r_cnt    <= '0;
            r_ev_vld <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            r_ev_vld <= i_cmd.issue;
            if (i_cmd.load) begin
                r_cnt   <= '0;
                r_found <= 1'b0;
            end else begin
                if (cnt_step) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                if (add_hit || rem_hit) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req     <= i_req;
            r_tok     <= i_token[TOK_W-1:0];
            r_now     <= i_now;
            r_elapsed <= '0;
        end else if (rem_hit) begin
            r_elapsed <= age;
        end
    end

    always_comb begin
        if (r_found) begin
            n_status = STAT_DONE;
        end else if (r_req == REQ_REMOVE) begin
            n_status = STAT_NOT_FOUND;
        end else begin
            n_status = STAT_FULL;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.post) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.post) begin
            r_out_status  <= n_status;
            r_out_elapsed <= r_elapsed;
        end
    end

    assign o_stat.cnt_end  = (r_cnt == CNT_W'(TABLE_SLOTS));
    assign o_stat.ev_busy  = r_ev_vld;
    assign o_stat.out_free = !r_out_vld || i_out_ready;

    assign o_out_valid = r_out_vld;
    assign o_status    = r_out_status;
    assign o_elapsed   = r_out_elapsed;

    `PTT_ASSERT_NOW(a_issue_in_range, cnt_step, r_cnt < CNT_W'(TABLE_SLOTS), "counter overrun")
    `PTT_ASSERT_NEXT(a_eval_follows_issue, i_cmd.issue, r_ev_vld, "issue without evaluation")
    `PTT_ASSERT_NOW(a_add_elapsed, i_cmd.post && (r_req == REQ_ADD), r_elapsed == '0, "add elapsed")

endmodule

### src/pending_token_table_with_timeout_top.sv
// top level of the pending token table with timeout
//
//  channel   | direction | tdata (low bit up)                 | tuser
//  ----------+-----------+------------------------------------+--------------
//  s_axis    | in        | token_value[63:0], now_time[95:64] | req_type
//  m_axis    | out       | elapsed_time[31:0]                 | status_code
//  cfg       | in        | expiry_limit on i_cfg_wr_data      | -
//
// each item is accepted, then the scan reads one slot per cycle over the whole table,
// evaluates the last slot, sees the scan drained and posts the result; the scan is bound
// by the single read port of the slot memories; after reset a clearing pass over all
// TABLE_SLOTS slots zeroes the valid store, with s_axis_tready low through it and
// until the sequencer is idle; configuration writes are taken at any time
// a result waits in the output register while the next item is accepted and
// scanned; a scan that finishes while it still waits holds until it is taken

module pending_token_table_with_timeout_top #(
    parameter int TABLE_SLOTS = 128,
    parameter int TOKEN_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: expiry_limit
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    // request items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // token_value[63:0], now_time[95:64]
    input  logic        s_axis_tuser,   // req_type[0]
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // elapsed_time[31:0]
    output logic [1:0]  m_axis_tuser    // status_code[1:0]
);
    import ptt_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer: clear pass, accept, scan, post
    ptt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // slot stores, expiry and match evaluation, result register
    ptt_datapath #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .TOKEN_BYTES (TOKEN_BYTES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req         (s_axis_tuser),
        .i_token       (s_axis_tdata[63:0]),
        .i_now         (s_axis_tdata[95:64]),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_status      (m_axis_tuser),
        .o_elapsed     (m_axis_tdata)
    );

endmodule
